// ===== src/lru_chunk_cache_manager_macros.svh =====
// ---------------------------------------------------------------------------
// LRU chunk cache manager assertion macros
// Shorthand for clocked checks in the cache manager.
// ---------------------------------------------------------------------------
`ifndef LRU_CHUNK_CACHE_MANAGER_MACROS_SVH
`define LRU_CHUNK_CACHE_MANAGER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LCC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcc check failed");

// Next-cycle implication, checked out of reset.
`define LCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcc check failed");

`endif

// ===== src/lcc_pkg.sv =====
// ---------------------------------------------------------------------------
// LRU chunk cache manager package
// Shared widths, codes and the result beat type.
// ---------------------------------------------------------------------------
package lcc_pkg;

  localparam int SLOTS_DEF    = 64;
  localparam int TAG_BITS_DEF = 20;

  localparam int KIND_W = 3;
  localparam int CTAG_W = 20;
  localparam int SIDX_W = 6;

  localparam logic [KIND_W-1:0] KIND_HINT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OK     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FAIL   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RESET  = 3'd4;

  localparam logic [1:0] MODE_FREE    = 2'd0;
  localparam logic [1:0] MODE_READING = 2'd1;
  localparam logic [1:0] MODE_CACHED  = 2'd2;

  typedef struct packed {
    logic              hit;
    logic [SIDX_W-1:0] slot_out;
    logic              issue_read;
    logic              evicted;
    logic [CTAG_W-1:0] evicted_tag;
    logic              no_slot;
    logic              duplicate;
  } rsp_t;

endpackage

// ===== src/lcc_req_if.sv =====
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one request beat.
// ---------------------------------------------------------------------------
interface lcc_req_if;
  logic                          valid;
  logic                          ready;
  logic [lcc_pkg::KIND_W-1:0]    req_type;
  logic [lcc_pkg::CTAG_W-1:0]    chunk_tag;
  logic [lcc_pkg::SIDX_W-1:0]    slot_index;

  modport source (output valid, req_type, chunk_tag, slot_index, input ready);
  modport sink (input valid, req_type, chunk_tag, slot_index, output ready);
endinterface

// ===== src/lcc_rsp_if.sv =====
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result beat.
// ---------------------------------------------------------------------------
interface lcc_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [lcc_pkg::SIDX_W-1:0] slot_out;
  logic                       issue_read;
  logic                       evicted;
  logic [lcc_pkg::CTAG_W-1:0] evicted_tag;
  logic                       no_slot;
  logic                       duplicate;

  modport source (output valid, hit, slot_out, issue_read, evicted, evicted_tag,
                  no_slot, duplicate, input ready);
  modport sink (input valid, hit, slot_out, issue_read, evicted, evicted_tag,
                no_slot, duplicate, output ready);
endinterface

// ===== src/lcc_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module lcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/lru_chunk_cache_manager.sv =====
// ---------------------------------------------------------------------------
// LRU chunk cache manager
// Fully associative LRU map of chunk numbers onto buffer slots, FIFO free list.
// ---------------------------------------------------------------------------
//
//  channel | dir | beat
//  --------+-----+----------------------------------------------------------
//  req     | in  | req_type, chunk_tag, slot_index
//  rsp     | out | hit, slot_out, issue_read, evicted, evicted_tag, no_slot,
//          |     | duplicate
//
//  One request at a time. Each pass over the slot store walks every slot
//  through its one read port; a hint or lookup takes one search pass
//  plus, where ranks move, one update pass. A failed read checks the slot
//  and, if it is reading, pushes it back on the free list; reset-all one pass.
//  After rst a clearing pass fills both stores; req.ready is low
//  meanwhile. A stalled rsp holds its beat; the next request is taken
//  while it waits, and held in DONE until the result register frees up.
//
`include "lru_chunk_cache_manager_macros.svh"

module lru_chunk_cache_manager #(
  parameter int SLOTS    = lcc_pkg::SLOTS_DEF,
  parameter int TAG_BITS = lcc_pkg::TAG_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  lcc_req_if.sink   req,
  lcc_rsp_if.source rsp
);
  localparam int SW = $clog2(SLOTS);
  localparam int CW = SW + 1;
  localparam int EW = TAG_BITS + 2 + SW;
  localparam int IW = ((SW > lcc_pkg::SIDX_W) ? SW : lcc_pkg::SIDX_W) + 1;

  typedef enum logic [8:0] {
    ST_INIT = 9'b000000001,
    ST_IDLE = 9'b000000010,
    ST_CHK  = 9'b000000100,
    ST_SCAN = 9'b000001000,
    ST_UPD  = 9'b000010000,
    ST_PUSH = 9'b000100000,
    ST_POP1 = 9'b001000000,
    ST_POP2 = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_t;

  typedef enum logic [3:0] {
    OP_FRESH  = 4'b0001,
    OP_INSERT = 4'b0010,
    OP_EVICT  = 4'b0100,
    OP_CLEAR  = 4'b1000
  } op_t;

  state_t state;
  op_t    op;

  logic [lcc_pkg::KIND_W-1:0] kind;
  logic [TAG_BITS-1:0]        key_tag;
  logic [SW-1:0]              s_reg;
  logic                       s_ok;
  logic [CW-1:0]              cnt;
  logic                       pv;
  logic [SW-1:0]              pa;

  logic                rd_found, ca_found, lru_found;
  logic [SW-1:0]       rd_slot, ca_slot, ca_rank, lru_slot, lru_rank;
  logic [TAG_BITS-1:0] lru_tag;

  logic [SW-1:0] tgt, rk, pslot;
  logic          dup_free;
  logic [SW-1:0] free_head;
  logic [CW-1:0] free_count;
  lcc_pkg::rsp_t res, out_data;
  logic          out_valid;

  // slot store: {tag, mode, rank}
  logic          s_we;
  logic [SW-1:0] s_waddr, s_raddr;
  logic [EW-1:0] s_wdata, s_rdata;
  // free list store
  logic          f_we;
  logic [SW-1:0] f_waddr, f_wdata, f_raddr, f_rdata;

  lcc_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_slot_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  lcc_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_free_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  logic [TAG_BITS-1:0] d_tag;
  logic [1:0]          d_mode;
  logic [SW-1:0]       d_rank;
  logic                d_cached;
  assign d_tag    = s_rdata[EW-1 -: TAG_BITS];
  assign d_mode   = s_rdata[SW+1:SW];
  assign d_rank   = s_rdata[SW-1:0];
  assign d_cached = (d_mode == lcc_pkg::MODE_CACHED);

  // tail of the free list: head + count, wrapped once
  logic [CW:0]   tail_sum;
  logic [SW-1:0] tail;
  logic [SW-1:0] head_inc;
  logic          sweep_end;
  logic          can_push;
  assign tail_sum  = {1'b0, free_head} + {1'b0, free_count};
  assign tail      = (tail_sum >= (CW+1)'(SLOTS)) ? SW'(tail_sum - (CW+1)'(SLOTS))
                                                  : SW'(tail_sum);
  assign head_inc  = (free_head == SW'(SLOTS - 1)) ? '0 : free_head + 1'b1;
  assign sweep_end = (cnt == CW'(SLOTS)) && !pv;
  assign can_push  = (free_count < CW'(SLOTS));

  assign req.ready = (state == ST_IDLE);

  // store ports
  always_comb begin
    s_we    = 1'b0;
    s_waddr = pa;
    s_wdata = s_rdata;
    s_raddr = cnt[SW-1:0];
    f_we    = 1'b0;
    f_waddr = tail;
    f_wdata = pslot;
    f_raddr = free_head;
    case (state)
      ST_INIT: begin
        s_we    = 1'b1;
        s_waddr = cnt[SW-1:0];
        s_wdata = '0;
        f_we    = 1'b1;
        f_waddr = cnt[SW-1:0];
        f_wdata = cnt[SW-1:0];
      end
      ST_IDLE: begin
        s_raddr = SW'(req.slot_index);
      end
      ST_UPD: begin
        s_we = pv;
        case (op)
          OP_FRESH: begin
            if (pa == tgt) begin
              s_wdata = {d_tag, d_mode, {SW{1'b0}}};
            end else if (dup_free && pa == pslot) begin
              s_wdata = {d_tag, lcc_pkg::MODE_FREE, {SW{1'b0}}};
            end else if (d_cached && d_rank < rk) begin
              s_wdata = {d_tag, d_mode, d_rank + 1'b1};
            end
          end
          OP_INSERT: begin
            if (pa == tgt) begin
              s_wdata = {d_tag, lcc_pkg::MODE_CACHED, {SW{1'b0}}};
            end else if (d_cached) begin
              s_wdata = {d_tag, d_mode, d_rank + 1'b1};
            end
          end
          OP_EVICT: begin
            if (pa == tgt) begin
              s_wdata = {d_tag, lcc_pkg::MODE_FREE, {SW{1'b0}}};
            end else if (d_cached && d_rank > rk) begin
              s_wdata = {d_tag, d_mode, d_rank - 1'b1};
            end
          end
          OP_CLEAR: begin
            // cached slots go back on the free list in slot order
            if (d_cached) begin
              s_wdata = {d_tag, lcc_pkg::MODE_FREE, {SW{1'b0}}};
              f_we    = pv && can_push;
              f_wdata = pa;
            end else begin
              s_wdata = {d_tag, d_mode, {SW{1'b0}}};
            end
          end
          default: s_we = 1'b0;
        endcase
      end
      ST_PUSH: begin
        f_we    = can_push;
        s_we    = (kind == lcc_pkg::KIND_FAIL);
        s_waddr = pslot;
        s_wdata = {key_tag, lcc_pkg::MODE_FREE, {SW{1'b0}}};
      end
      ST_POP2: begin
        s_we    = 1'b1;
        s_waddr = f_rdata;
        s_wdata = {key_tag, lcc_pkg::MODE_READING, {SW{1'b0}}};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      cnt        <= '0;
      pv         <= 1'b0;
      out_valid  <= 1'b0;
      free_head  <= '0;
      free_count <= CW'(SLOTS);
    end else begin
      // drop the result once taken
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      // sweep counter: advance the read address, track the data beat
      if (state == ST_SCAN || state == ST_UPD) begin
        if (cnt != CW'(SLOTS)) begin
          cnt <= cnt + 1'b1;
          pv  <= 1'b1;
          pa  <= cnt[SW-1:0];
        end else begin
          pv <= 1'b0;
        end
      end
      case (state)
        ST_INIT: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(SLOTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            kind      <= req.req_type;
            key_tag   <= TAG_BITS'(req.chunk_tag);
            s_reg     <= SW'(req.slot_index);
            s_ok      <= IW'(req.slot_index) < IW'(SLOTS);
            res       <= '0;
            cnt       <= '0;
            pv        <= 1'b0;
            rd_found  <= 1'b0;
            ca_found  <= 1'b0;
            lru_found <= 1'b0;
            dup_free  <= 1'b0;
            case (req.req_type)
              lcc_pkg::KIND_HINT, lcc_pkg::KIND_LOOKUP: state <= ST_SCAN;
              lcc_pkg::KIND_OK, lcc_pkg::KIND_FAIL:     state <= ST_CHK;
              lcc_pkg::KIND_RESET: begin
                op    <= OP_CLEAR;
                state <= ST_UPD;
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_CHK: begin
          if (!s_ok || d_mode != lcc_pkg::MODE_READING) begin
            state <= ST_DONE;
          end else begin
            key_tag <= d_tag;
            pslot   <= s_reg;
            if (kind == lcc_pkg::KIND_FAIL) begin
              res.slot_out <= lcc_pkg::SIDX_W'(s_reg);
              state        <= ST_PUSH;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (pv) begin
            if (d_mode == lcc_pkg::MODE_READING && d_tag == key_tag && !rd_found) begin
              rd_found <= 1'b1;
              rd_slot  <= pa;
            end
            if (d_cached && d_tag == key_tag && !ca_found) begin
              ca_found <= 1'b1;
              ca_slot  <= pa;
              ca_rank  <= d_rank;
            end
            if (d_cached && (!lru_found || d_rank > lru_rank)) begin
              lru_found <= 1'b1;
              lru_slot  <= pa;
              lru_rank  <= d_rank;
              lru_tag   <= d_tag;
            end
          end
          if (sweep_end) begin
            cnt <= '0;
            tgt <= ca_slot;
            rk  <= ca_rank;
            op  <= OP_FRESH;
            if (kind == lcc_pkg::KIND_HINT) begin
              if (rd_found) begin
                res.hit      <= 1'b1;
                res.slot_out <= lcc_pkg::SIDX_W'(rd_slot);
                state        <= ST_DONE;
              end else if (ca_found) begin
                res.hit      <= 1'b1;
                res.slot_out <= lcc_pkg::SIDX_W'(ca_slot);
                state        <= ST_UPD;
              end else if (free_count != '0) begin
                state <= ST_POP1;
              end else if (lru_found) begin
                res.evicted     <= 1'b1;
                res.evicted_tag <= lcc_pkg::CTAG_W'(lru_tag);
                op              <= OP_EVICT;
                tgt             <= lru_slot;
                rk              <= lru_rank;
                pslot           <= lru_slot;
                state           <= ST_UPD;
              end else begin
                res.no_slot <= 1'b1;
                state       <= ST_DONE;
              end
            end else if (kind == lcc_pkg::KIND_OK) begin
              if (ca_found) begin
                // duplicate: freshen the cached copy, free the completing slot
                res.hit       <= 1'b1;
                res.duplicate <= 1'b1;
                res.slot_out  <= lcc_pkg::SIDX_W'(ca_slot);
                dup_free      <= 1'b1;
              end else begin
                res.slot_out <= lcc_pkg::SIDX_W'(s_reg);
                op           <= OP_INSERT;
                tgt          <= s_reg;
              end
              state <= ST_UPD;
            end else begin
              if (ca_found) begin
                res.hit      <= 1'b1;
                res.slot_out <= lcc_pkg::SIDX_W'(ca_slot);
                state        <= ST_UPD;
              end else begin
                state <= ST_DONE;
              end
            end
          end
        end
        ST_UPD: begin
          if (op == OP_CLEAR && pv && d_cached && can_push) begin
            free_count <= free_count + 1'b1;
          end
          if (sweep_end) begin
            if (op == OP_EVICT || (op == OP_FRESH && dup_free)) begin
              state <= ST_PUSH;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_PUSH: begin
          if (can_push) begin
            free_count <= free_count + 1'b1;
          end
          state <= (kind == lcc_pkg::KIND_HINT) ? ST_POP1 : ST_DONE;
        end
        ST_POP1: begin
          state <= ST_POP2;
        end
        ST_POP2: begin
          free_head      <= head_inc;
          free_count     <= free_count - 1'b1;
          res.issue_read <= 1'b1;
          res.slot_out   <= lcc_pkg::SIDX_W'(f_rdata);
          state          <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_INIT;
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.hit         = out_data.hit;
  assign rsp.slot_out    = out_data.slot_out;
  assign rsp.issue_read  = out_data.issue_read;
  assign rsp.evicted     = out_data.evicted;
  assign rsp.evicted_tag = out_data.evicted_tag;
  assign rsp.no_slot     = out_data.no_slot;
  assign rsp.duplicate   = out_data.duplicate;

  `LCC_ASSERT_NOW(a_count_bound, 1'b1, free_count <= CW'(SLOTS))
  `LCC_ASSERT_NEXT(a_leave_idle, req.valid && req.ready, state != ST_IDLE)
  `LCC_ASSERT_NOW(a_evict_reads, rsp.valid && rsp.evicted, rsp.issue_read && !rsp.no_slot)
  `LCC_ASSERT_NOW(a_pop_nonempty, state == ST_POP2, free_count != '0)

endmodule
